@@ sv/gsv_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shadowcast visibility package
// Shared types, request and status codes, and default sizes for the
// grid shadowcast visibility block.
// ----------------------------------------------------------------------------
package gsv_pkg;

    // Default sizes, used as parameter defaults on the top level.
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_STACK_DEPTH = 256;

    // Width and saturation value of the visible tile count.
    localparam int             CNT_W   = 13;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request type codes.
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_COMPUTE = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAP_WIDTH  = 1'b0;
    localparam logic CFG_MAP_HEIGHT = 1'b1;

    // One request item.
    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] tile_x;
        logic [5:0] tile_y;
        logic       opaque;
        logic       clear_before;
    } t_in_req;

    // One response item.
    typedef struct packed {
        logic             visible;
        logic [1:0]       status;
        logic [CNT_W-1:0] visible_count;
    } t_out_rsp;

    // Controller states.
    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_CLR,
        S_ORG_RD,
        S_ORG_EV,
        S_PUSH0,
        S_POP,
        S_ROW_LD,
        S_ROW_MUL,
        S_DIV_LO_GO,
        S_DIV_LO,
        S_DIV_HI_GO,
        S_DIV_HI,
        S_ROW_CHK,
        S_TILE_RD,
        S_TILE_EV,
        S_ROW_END,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic req_load;
        logic clr_init;
        logic clr_vis;
        logic opa_wr;
        logic vis_rd;
        logic comp_init;
        logic org_mark;
        logic push_init;
        logic pop;
        logic row_load;
        logic row_mul;
        logic div_start;
        logic div_sel_hi;
        logic lo_latch;
        logic hi_latch;
        logic col_init;
        logic tile_rd;
        logic tile_ev;
        logic row_end;
        logic quad_next;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       sweep_done;
        logic       div_done;
        logic       row_empty;
        logic       col_last;
        logic       sp_zero;
        logic       quad_last;
        logic [1:0] req_type;
        logic       req_in_map;
        logic       clear_before;
        logic       out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ sv/gsv_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Serial unsigned divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gsv_div #(
    parameter int NW  = 19,
    parameter int DVW = 10
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DVW-1:0] i_den,
    output logic                o_done,
    output logic [NW-1:0]       o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;

    logic [DVW:0]   rem_sh;
    logic           ge;
    logic [DVW:0]   n_rem;

    // One restoring step: shift in the next numerator bit and try to subtract.
    always_comb begin
        rem_sh = {r_rem, r_num[NW-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Control: busy flag, step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Data: the numerator register collects quotient bits from the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], ge};
            r_rem <= n_rem[DVW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

@@ sv/gsv_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shadowcast visibility datapath
// Opacity and visibility maps, row stack, slope arithmetic, configuration
// registers and the response register.
// ----------------------------------------------------------------------------
module gsv_dp #(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int STACK_DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [6:0]        i_cfg_data,
    input  wire gsv_pkg::t_in_req  i_in_req,
    output gsv_pkg::t_out_rsp      o_out_rsp,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    input  wire gsv_pkg::t_dp_cmd  i_cmd,
    output gsv_pkg::t_dp_sts       o_sts
);
    import gsv_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW    = $clog2(MAXD + 2);
    localparam int SW    = DW + 3;
    localparam int CLW   = DW + 2;
    localparam int PW    = DW + SW + 2;
    localparam int GW    = ((DW > 6) ? DW : 6) + 3;
    localparam int MWW   = $clog2(MAX_WIDTH + 1);
    localparam int MHW   = $clog2(MAX_HEIGHT + 1);
    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = $clog2(STACK_DEPTH);
    localparam int EW    = DW + 4 * SW;
    localparam int MW_RST = (64 > MAX_WIDTH) ? MAX_WIDTH : 64;
    localparam int MH_RST = (64 > MAX_HEIGHT) ? MAX_HEIGHT : 64;

    // Quadrant codes.
    localparam logic [1:0] QD_NORTH = 2'd0;
    localparam logic [1:0] QD_SOUTH = 2'd1;
    localparam logic [1:0] QD_EAST  = 2'd2;
    localparam logic [1:0] QD_WEST  = 2'd3;

    // Configuration and request registers.
    logic [MWW-1:0] r_map_w;
    logic [MHW-1:0] r_map_h;
    t_in_req        r_req;
    logic [6:0]     cfg_v;

    // Control registers.
    logic [AW-1:0]    r_sweep;
    logic [SPW-1:0]   r_sp;
    logic [1:0]       r_quad;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_out_valid;

    // Row and tile payload registers.
    logic [DW-1:0]         r_d;
    logic signed [SW-1:0]  r_sn, r_sd, r_en, r_ed;
    logic signed [PW-1:0]  r_dsn, r_den, r_csd, r_ced;
    logic signed [CLW-1:0] r_lo, r_hi, r_col;
    logic                  r_prev_valid, r_prev_op;
    logic                  r_tile_in;
    logic                  r_opa_q, r_vis_q;
    logic [AW-1:0]         r_addr;
    logic [EW-1:0]         r_stk_q;
    t_out_rsp              r_out_rsp;

    // Memories.
    logic           m_opa [DEPTH];
    logic           m_vis [DEPTH];
    logic [EW-1:0]  m_stk [STACK_DEPTH];

    // Combinational signals.
    logic                  req_in_map;
    logic [AW-1:0]         req_addr;
    logic signed [GW-1:0]  ox, oy, dd, cc, tx, ty;
    logic                  tile_in;
    logic [AW-1:0]         tile_addr;
    logic                  tile_op, sym;
    logic                  mark_we;
    logic                  edge_open, edge_close, row_push;
    logic                  push_req, push_ok, sp_full;
    logic [EW-1:0]         push_data;
    logic [SPW-1:0]        sp_m1;
    logic signed [CLW-1:0] col_m1;
    logic signed [SW-1:0]  col_sn, d_sd;
    logic [DW-1:0]         d_next;
    logic signed [PW-1:0]  dsg;
    logic signed [PW-1:0]  a_lo, a_hi, a_sel;
    logic [PW-1:0]         div_num;
    logic [SW-1:0]         div_den;
    logic                  div_done;
    logic [PW-1:0]         div_q;
    logic [PW-1:0]         f_lo, f_hi;
    logic                  opa_we, opa_wd, vis_we, vis_wd;
    logic [AW-1:0]         opa_wa, vis_wa, vis_ra;
    logic                  out_free;
    logic                  req_known;

    // Configuration writes: zero acts as one, large values clamp.
    assign o_cfg_ready = 1'b1;
    assign cfg_v = (i_cfg_data == '0) ? 7'd1 : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w <= MWW'(MW_RST);
            r_map_h <= MHW'(MH_RST);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MAP_WIDTH) begin
                r_map_w <= (32'(cfg_v) > 32'(MAX_WIDTH)) ? MWW'(MAX_WIDTH) : MWW'(cfg_v);
            end else begin
                r_map_h <= (32'(cfg_v) > 32'(MAX_HEIGHT)) ? MHW'(MAX_HEIGHT) : MHW'(cfg_v);
            end
        end
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_req <= i_in_req;
        end
    end

    assign req_in_map = ((GW-1)'(r_req.tile_x) < (GW-1)'(r_map_w)) &&
                        ((GW-1)'(r_req.tile_y) < (GW-1)'(r_map_h));
    assign req_addr   = {YW'(r_req.tile_y), XW'(r_req.tile_x)};
    assign req_known  = (r_req.req_type == REQ_WRITE) || (r_req.req_type == REQ_COMPUTE) ||
                        (r_req.req_type == REQ_READ);

    // Map coordinates of the current tile in the current quadrant.
    always_comb begin
        ox = $signed(GW'(r_req.tile_x));
        oy = $signed(GW'(r_req.tile_y));
        dd = $signed(GW'(r_d));
        cc = GW'(r_col);
        case (r_quad)
            QD_NORTH: begin tx = ox + cc; ty = oy - dd; end
            QD_SOUTH: begin tx = ox + cc; ty = oy + dd; end
            QD_EAST:  begin tx = ox + dd; ty = oy + cc; end
            default:  begin tx = ox - dd; ty = oy + cc; end
        endcase
        tile_in = !tx[GW-1] && !ty[GW-1] &&
                  (tx[GW-2:0] < (GW-1)'(r_map_w)) && (ty[GW-2:0] < (GW-1)'(r_map_h));
        tile_addr = {ty[YW-1:0], tx[XW-1:0]};
    end

    // Tile evaluation: off-map tiles are opaque; in-map tiles that are opaque or symmetric are seen.
    assign tile_op = !r_tile_in || r_opa_q;
    assign sym     = (r_csd >= r_dsn) && (r_ced <= r_den);
    assign mark_we = !r_vis_q && (i_cmd.org_mark ||
                     (i_cmd.tile_ev && r_tile_in && (tile_op || sym)));

    // Slope values that a tile boundary produces.
    assign col_m1 = r_col - CLW'(1);
    assign col_sn = $signed({col_m1, 1'b1});
    assign d_sd   = $signed(SW'({r_d, 1'b0}));
    assign d_next = r_d + 1'b1;
    assign dsg    = PW'($signed({1'b0, r_d}));

    assign edge_open  = i_cmd.tile_ev && r_prev_valid && r_prev_op && !tile_op;
    assign edge_close = i_cmd.tile_ev && r_prev_valid && !r_prev_op && tile_op;
    assign row_push   = i_cmd.row_end && !r_prev_op;

    // Row stack push selection.
    always_comb begin
        push_req = i_cmd.push_init || edge_close || row_push;
        sp_full  = (r_sp == SPW'(STACK_DEPTH));
        push_ok  = push_req && !sp_full;
        sp_m1    = r_sp - 1'b1;
        if (i_cmd.push_init) begin
            push_data = {DW'(1), -SW'(1), SW'(1), SW'(1), SW'(1)};
        end else if (edge_close) begin
            push_data = {d_next, r_sn, r_sd, col_sn, d_sd};
        end else begin
            push_data = {d_next, r_sn, r_sd, r_en, r_ed};
        end
    end

    // Stack memory.
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            m_stk[r_sp[SAW-1:0]] <= push_data;
        end
        if (i_cmd.pop) begin
            r_stk_q <= m_stk[sp_m1[SAW-1:0]];
        end
    end

    // Map memory ports.
    always_comb begin
        opa_we = i_cmd.clr_init || i_cmd.opa_wr;
        opa_wa = i_cmd.clr_init ? r_sweep : req_addr;
        opa_wd = i_cmd.opa_wr && r_req.opaque;
        vis_we = i_cmd.clr_init || i_cmd.clr_vis || mark_we;
        vis_wa = mark_we ? r_addr : r_sweep;
        vis_wd = mark_we;
        vis_ra = i_cmd.tile_rd ? tile_addr : req_addr;
    end

    always_ff @(posedge i_clk) begin
        if (opa_we) begin
            m_opa[opa_wa] <= opa_wd;
        end
        if (i_cmd.tile_rd) begin
            r_opa_q <= m_opa[tile_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (vis_we) begin
            m_vis[vis_wa] <= vis_wd;
        end
        if (i_cmd.tile_rd || i_cmd.vis_rd) begin
            r_vis_q <= m_vis[vis_ra];
            r_addr  <= vis_ra;
        end
    end

    // Control registers: sweep, stack pointer, quadrant, count, overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep <= '0;
            r_sp    <= '0;
            r_quad  <= QD_NORTH;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.clr_init || i_cmd.clr_vis) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.comp_init) begin
                r_sp    <= '0;
                r_quad  <= QD_NORTH;
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (push_ok) begin
                    r_sp <= r_sp + 1'b1;
                end else if (i_cmd.pop) begin
                    r_sp <= sp_m1;
                end
                if (push_req && sp_full) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.quad_next) begin
                    r_quad <= r_quad + 1'b1;
                end
                if (mark_we && (r_count != CNT_MAX)) begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Divider operands: floor division of a signed value by a positive one.
    assign a_lo    = (r_dsn <<< 1) + PW'(r_sd);
    assign a_hi    = PW'(r_ed) - (r_den <<< 1);
    assign a_sel   = i_cmd.div_sel_hi ? a_hi : a_lo;
    assign div_num = a_sel[PW-1] ? ~a_sel : a_sel;
    assign div_den = i_cmd.div_sel_hi ? {r_ed[SW-2:0], 1'b0} : {r_sd[SW-2:0], 1'b0};
    assign f_lo    = a_lo[PW-1] ? ~div_q : div_q;
    assign f_hi    = a_hi[PW-1] ? ~div_q : div_q;

    gsv_div #(
        .NW  (PW),
        .DVW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Row and tile registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            {r_d, r_sn, r_sd, r_en, r_ed} <= r_stk_q;
        end
        if (i_cmd.row_mul) begin
            r_dsn <= dsg * PW'(r_sn);
            r_den <= dsg * PW'(r_en);
        end
        if (i_cmd.lo_latch) begin
            r_lo <= $signed(f_lo[CLW-1:0]);
        end
        if (i_cmd.hi_latch) begin
            r_hi <= -$signed(f_hi[CLW-1:0]);
        end
        if (i_cmd.col_init) begin
            r_col        <= r_lo;
            r_prev_valid <= 1'b0;
            r_prev_op    <= 1'b0;
        end
        if (i_cmd.tile_rd) begin
            r_csd     <= PW'(r_col) * PW'(r_sd);
            r_ced     <= PW'(r_col) * PW'(r_ed);
            r_tile_in <= tile_in;
        end
        if (i_cmd.tile_ev) begin
            r_col        <= r_col + CLW'(1);
            r_prev_op    <= tile_op;
            r_prev_valid <= 1'b1;
            if (edge_open) begin
                r_sn  <= col_sn;
                r_sd  <= d_sd;
                r_dsn <= dsg * PW'(col_sn);
            end
        end
    end

    // Response register.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rsp.visible <= (r_req.req_type == REQ_READ) && req_in_map && r_vis_q;
            if (req_known && !req_in_map) begin
                r_out_rsp.status <= ST_OUTSIDE;
            end else if ((r_req.req_type == REQ_COMPUTE) && r_ovf) begin
                r_out_rsp.status <= ST_OVERFLOW;
            end else begin
                r_out_rsp.status <= ST_OK;
            end
            r_out_rsp.visible_count <= r_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Status toward the controller.
    always_comb begin
        o_sts.sweep_done   = &r_sweep;
        o_sts.div_done     = div_done;
        o_sts.row_empty    = (r_lo > r_hi);
        o_sts.col_last     = (r_col == r_hi);
        o_sts.sp_zero      = (r_sp == '0);
        o_sts.quad_last    = (r_quad == QD_WEST);
        o_sts.req_type     = r_req.req_type;
        o_sts.req_in_map   = req_in_map;
        o_sts.clear_before = r_req.clear_before;
        o_sts.out_free     = out_free;
    end

    // The stack pointer never passes the stack depth.
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("row stack pointer out of range");

    // A pop is only issued on a non-empty stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_sp != '0))
        else $error("pop from empty row stack");

    // Every evaluated tile lies inside the row's column range.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tile_ev |-> ((r_col >= r_lo) && (r_col <= r_hi)))
        else $error("tile column outside row range");

endmodule
`default_nettype wire

@@ sv/gsv_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Shadowcast visibility controller
// State machine that sequences map clears, requests and the row walk of
// the shadowcast.
// ----------------------------------------------------------------------------
module gsv_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire gsv_pkg::t_dp_sts i_sts,
    output gsv_pkg::t_dp_cmd      o_cmd
);
    import gsv_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_sts.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (!i_sts.req_in_map) begin
                    n_state = S_FINISH;
                end else if (i_sts.req_type == REQ_READ) begin
                    n_state = S_RD_WAIT;
                end else if (i_sts.req_type == REQ_COMPUTE) begin
                    n_state = i_sts.clear_before ? S_CLR : S_ORG_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RD_WAIT:   n_state = S_FINISH;
            S_CLR: begin
                if (i_sts.sweep_done) n_state = S_ORG_RD;
            end
            S_ORG_RD:    n_state = S_ORG_EV;
            S_ORG_EV:    n_state = S_PUSH0;
            S_PUSH0:     n_state = S_POP;
            S_POP: begin
                if (!i_sts.sp_zero) begin
                    n_state = S_ROW_LD;
                end else if (i_sts.quad_last) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_PUSH0;
                end
            end
            S_ROW_LD:    n_state = S_ROW_MUL;
            S_ROW_MUL:   n_state = S_DIV_LO_GO;
            S_DIV_LO_GO: n_state = S_DIV_LO;
            S_DIV_LO: begin
                if (i_sts.div_done) n_state = S_DIV_HI_GO;
            end
            S_DIV_HI_GO: n_state = S_DIV_HI;
            S_DIV_HI: begin
                if (i_sts.div_done) n_state = S_ROW_CHK;
            end
            S_ROW_CHK:   n_state = i_sts.row_empty ? S_POP : S_TILE_RD;
            S_TILE_RD:   n_state = S_TILE_EV;
            S_TILE_EV:   n_state = i_sts.col_last ? S_ROW_END : S_TILE_RD;
            S_ROW_END:   n_state = S_POP;
            S_FINISH: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:     n_state = S_INIT;
        endcase
    end

    // Commands per state.
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_INIT:   o_cmd.clr_init = 1'b1;
            S_IDLE:   o_cmd.req_load = i_in_valid;
            S_DISPATCH: begin
                if (i_sts.req_in_map) begin
                    o_cmd.opa_wr    = (i_sts.req_type == REQ_WRITE);
                    o_cmd.vis_rd    = (i_sts.req_type == REQ_READ);
                    o_cmd.comp_init = (i_sts.req_type == REQ_COMPUTE);
                end
            end
            S_CLR:       o_cmd.clr_vis   = 1'b1;
            S_ORG_RD:    o_cmd.vis_rd    = 1'b1;
            S_ORG_EV:    o_cmd.org_mark  = 1'b1;
            S_PUSH0:     o_cmd.push_init = 1'b1;
            S_POP: begin
                o_cmd.pop       = !i_sts.sp_zero;
                o_cmd.quad_next = i_sts.sp_zero && !i_sts.quad_last;
            end
            S_ROW_LD:    o_cmd.row_load  = 1'b1;
            S_ROW_MUL:   o_cmd.row_mul   = 1'b1;
            S_DIV_LO_GO: o_cmd.div_start = 1'b1;
            S_DIV_LO:    o_cmd.lo_latch  = i_sts.div_done;
            S_DIV_HI_GO: begin
                o_cmd.div_start  = 1'b1;
                o_cmd.div_sel_hi = 1'b1;
            end
            S_DIV_HI: begin
                o_cmd.div_sel_hi = 1'b1;
                o_cmd.hi_latch   = i_sts.div_done;
            end
            S_ROW_CHK:   o_cmd.col_init  = !i_sts.row_empty;
            S_TILE_RD:   o_cmd.tile_rd   = 1'b1;
            S_TILE_EV:   o_cmd.tile_ev   = 1'b1;
            S_ROW_END:   o_cmd.row_end   = 1'b1;
            S_FINISH:    o_cmd.out_load  = i_sts.out_free;
            default:     o_cmd           = '0;
        endcase
    end

    // An accepted request is always dispatched in the next cycle.
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");

    // A tile is evaluated only right after its maps were read.
    a_tile_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TILE_EV) |-> ($past(r_state) == S_TILE_RD))
        else $error("tile evaluated without a read");

    // A response is loaded only when the response register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("response loaded over a pending response");

endmodule
`default_nettype wire

@@ sv/grid_shadowcast_visibility.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Grid shadowcast visibility
// Symmetric shadowcasting field of view over a one-bit opacity map, with a
// one-bit visibility map that is read back tile by tile.
//
//   Channel   Direction  Handshake            Payload
//   in        input      i_in_valid/o_in_stall   i_in_req  (t_in_req)
//   out       output     o_out_valid/i_out_stall o_out_rsp (t_out_rsp)
//   cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// Write and read requests each give one response.
// A compute first clears the visibility map when clear_before is set, then
// walks the rows: each popped row takes two serial divisions, and each
// scanned tile takes a map read and an evaluation; the serial divider and
// the single map read port set the pace of the walk.
// After reset a clearing pass over all map addresses runs with o_in_stall high.
// A stalled response is held in the output register while the next request
// is accepted and worked on.
// ----------------------------------------------------------------------------
module grid_shadowcast_visibility #(
    parameter int MAX_WIDTH   = gsv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = gsv_pkg::DEF_MAX_HEIGHT,
    parameter int STACK_DEPTH = gsv_pkg::DEF_STACK_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gsv_pkg::t_in_req  i_in_req,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output gsv_pkg::t_out_rsp      o_out_rsp,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [6:0]        i_cfg_data
);
    import gsv_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer.
    gsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Maps, row stack and arithmetic.
    gsv_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .o_out_rsp   (o_out_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
`default_nettype wire
